// ===== hdl/fvbt_pkg.sv =====
// Shared types, constants and four-valued logic functions of the table engine.
package fvbt_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int SIZE_W      = 7;
  localparam int WORD_W      = 2 * MAX_ROWS;

  // Cell values.
  localparam logic [1:0] V_FALSE = 2'd0;
  localparam logic [1:0] V_TRUE  = 2'd1;
  localparam logic [1:0] V_UNDEF = 2'd2;
  localparam logic [1:0] V_ERROR = 2'd3;

  // Actions.
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_READ  = 3'd2;
  localparam logic [2:0] ACT_ROWQ  = 3'd3;
  localparam logic [2:0] ACT_COLQ  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Register indexes.
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic [2:0]       action;
    logic [COL_W-1:0] col_index;
    logic [ROW_W-1:0] row_index;
    logic [1:0]       cell_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  cell_out;
    logic [1:0]  and_fold;
    logic [1:0]  or_fold;
    logic [15:0] true_count;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_CLEAR, CMD_WRITE, CMD_READ, CMD_ROWQ, CMD_COLQ
  } cmd_kind_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        status;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [1:0]        val;
    logic [SIZE_W-1:0] len;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_RMW, S_FOLD, S_FIN
  } back_state_t;

  function automatic logic [1:0] and4(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    if (a == V_FALSE || a == V_ERROR) begin
      r = a;
    end else if (b == V_FALSE || b == V_UNDEF || b == V_ERROR) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic [1:0] or4(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    if (a == V_TRUE || a == V_ERROR) begin
      r = a;
    end else if (b == V_TRUE || b == V_UNDEF || b == V_ERROR) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== hdl/fvbt_front.sv =====
// Front end: configuration registers, ready flag, active sizes and classification.
module fvbt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_data,
  input  logic                  accept,
  input  fvbt_pkg::in_item_t    item,
  output fvbt_pkg::cmd_t        cmd
);

  logic [6:0]                  columns_in_use;
  logic [6:0]                  rows_in_use;
  logic                        table_ready;
  logic [fvbt_pkg::SIZE_W-1:0] active_cols;
  logic [fvbt_pkg::SIZE_W-1:0] active_rows;
  logic [fvbt_pkg::SIZE_W-1:0] clamp_cols;
  logic [fvbt_pkg::SIZE_W-1:0] clamp_rows;
  logic                        bad_col;
  logic                        bad_row;

  // Sizes latched by a clear: zero counts as one, large values stop at the table size.
  always_comb begin
    if (columns_in_use == '0) begin
      clamp_cols = fvbt_pkg::SIZE_W'(1);
    end else if (columns_in_use > fvbt_pkg::SIZE_W'(fvbt_pkg::MAX_COLS)) begin
      clamp_cols = fvbt_pkg::SIZE_W'(fvbt_pkg::MAX_COLS);
    end else begin
      clamp_cols = columns_in_use;
    end
    if (rows_in_use == '0) begin
      clamp_rows = fvbt_pkg::SIZE_W'(1);
    end else if (rows_in_use > fvbt_pkg::SIZE_W'(fvbt_pkg::MAX_ROWS)) begin
      clamp_rows = fvbt_pkg::SIZE_W'(fvbt_pkg::MAX_ROWS);
    end else begin
      clamp_rows = rows_in_use;
    end
  end

  // Configuration writes and the state that a clear sets.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 7'd64;
      rows_in_use    <= 7'd64;
      table_ready    <= 1'b0;
      active_cols    <= '0;
      active_rows    <= '0;
    end else begin
      if (cfg_we && cfg_index == fvbt_pkg::REG_COLS) begin
        columns_in_use <= cfg_data;
      end
      if (cfg_we && cfg_index == fvbt_pkg::REG_ROWS) begin
        rows_in_use <= cfg_data;
      end
      if (accept && item.action == fvbt_pkg::ACT_CLEAR) begin
        table_ready <= 1'b1;
        active_cols <= clamp_cols;
        active_rows <= clamp_rows;
      end
    end
  end

  // Classify the incoming item; not ready is checked before the index.
  always_comb begin
    bad_col    = {1'b0, item.col_index} >= active_cols;
    bad_row    = {1'b0, item.row_index} >= active_rows;
    cmd.kind   = fvbt_pkg::CMD_NONE;
    cmd.status = fvbt_pkg::ST_OK;
    cmd.col    = item.col_index;
    cmd.row    = item.row_index;
    cmd.val    = item.cell_in;
    cmd.len    = active_cols;
    case (item.action)
      fvbt_pkg::ACT_CLEAR: begin
        cmd.kind = fvbt_pkg::CMD_CLEAR;
      end
      fvbt_pkg::ACT_WRITE, fvbt_pkg::ACT_READ: begin
        if (!table_ready) begin
          cmd.status = fvbt_pkg::ST_NOT_READY;
        end else if (bad_col || bad_row) begin
          cmd.status = fvbt_pkg::ST_BAD_INDEX;
        end else if (item.action == fvbt_pkg::ACT_WRITE) begin
          cmd.kind = fvbt_pkg::CMD_WRITE;
        end else begin
          cmd.kind = fvbt_pkg::CMD_READ;
        end
      end
      fvbt_pkg::ACT_ROWQ: begin
        if (!table_ready) begin
          cmd.status = fvbt_pkg::ST_NOT_READY;
        end else if (bad_row) begin
          cmd.status = fvbt_pkg::ST_BAD_INDEX;
        end else begin
          cmd.kind = fvbt_pkg::CMD_ROWQ;
        end
      end
      fvbt_pkg::ACT_COLQ: begin
        cmd.len = active_rows;
        if (!table_ready) begin
          cmd.status = fvbt_pkg::ST_NOT_READY;
        end else if (bad_col) begin
          cmd.status = fvbt_pkg::ST_BAD_INDEX;
        end else begin
          cmd.kind = fvbt_pkg::CMD_COLQ;
        end
      end
      default: begin
        cmd.kind = fvbt_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

// ===== hdl/fvbt_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
module fvbt_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  fvbt_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output fvbt_pkg::cmd_t rdata
);

  fvbt_pkg::cmd_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = slots[rptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== hdl/fvbt_back.sv =====
// Back end: cell and count memories, clear sweep, read-modify-write and line folds.
module fvbt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  fvbt_pkg::cmd_t      q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output fvbt_pkg::out_item_t result
);

  // One word per column, holding every row of that column.
  logic [fvbt_pkg::WORD_W-1:0]      cells [fvbt_pkg::MAX_COLS];
  logic [fvbt_pkg::COUNT_WIDTH-1:0] rcnt  [fvbt_pkg::MAX_ROWS];
  logic [fvbt_pkg::COUNT_WIDTH-1:0] ccnt  [fvbt_pkg::MAX_COLS];

  fvbt_pkg::back_state_t            state, state_next;
  fvbt_pkg::cmd_t                   cmd, cmd_next;
  fvbt_pkg::out_item_t              res, res_next;
  logic [fvbt_pkg::COL_W-1:0]       idx, idx_next;
  logic [1:0]                       acc_and, acc_and_next;
  logic [1:0]                       acc_or, acc_or_next;
  logic                             out_valid;

  logic                             mem_we, mem_re;
  logic [fvbt_pkg::COL_W-1:0]       mem_waddr, mem_raddr;
  logic [fvbt_pkg::WORD_W-1:0]      mem_wdata, mem_rdata;
  logic                             cnt_re, rc_we, cc_we;
  logic [fvbt_pkg::ROW_W-1:0]       rc_addr;
  logic [fvbt_pkg::COL_W-1:0]       cc_addr;
  logic [fvbt_pkg::COUNT_WIDTH-1:0] rc_wdata, cc_wdata, rc_q, cc_q;
  logic [fvbt_pkg::ROW_W-1:0]       sel;
  logic [1:0]                       slice;
  logic [fvbt_pkg::COUNT_WIDTH-1:0] cnt_sel;

  assign empty  = !out_valid;
  assign slice  = mem_rdata[{sel, 1'b0} +: 2];

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= cells[mem_raddr];
    end
    if (rc_we) begin
      rcnt[rc_addr] <= rc_wdata;
    end
    if (cc_we) begin
      ccnt[cc_addr] <= cc_wdata;
    end
    if (cnt_re) begin
      rc_q <= rcnt[rc_addr];
      cc_q <= ccnt[cc_addr];
    end
  end

  // Sequencer registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fvbt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fvbt_pkg::S_FIN && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    res     <= res_next;
    idx     <= idx_next;
    acc_and <= acc_and_next;
    acc_or  <= acc_or_next;
    if (state == fvbt_pkg::S_FIN && (!out_valid || pop)) begin
      result <= res;
    end
  end

  // Next state, memory controls and result.
  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    res_next     = res;
    idx_next     = idx;
    acc_and_next = acc_and;
    acc_or_next  = acc_or;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cmd.col;
    mem_raddr    = cmd.col;
    mem_wdata    = mem_rdata;
    cnt_re       = 1'b0;
    rc_we        = 1'b0;
    cc_we        = 1'b0;
    rc_addr      = cmd.row;
    cc_addr      = cmd.col;
    rc_wdata     = (rc_q == '1) ? rc_q : rc_q + 1'b1;
    cc_wdata     = (cc_q == '1) ? cc_q : cc_q + 1'b1;
    sel          = cmd.row;
    cnt_sel      = (cmd.kind == fvbt_pkg::CMD_ROWQ) ? rc_q : cc_q;
    case (state)
      fvbt_pkg::S_IDLE: begin
        res_next     = '0;
        res_next.status = q_head.status;
        idx_next     = '0;
        acc_and_next = fvbt_pkg::V_TRUE;
        acc_or_next  = fvbt_pkg::V_FALSE;
        rc_addr      = q_head.row;
        cc_addr      = q_head.col;
        mem_raddr    = (q_head.kind == fvbt_pkg::CMD_ROWQ) ? '0 : q_head.col;
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_next = q_head;
          mem_re   = 1'b1;
          cnt_re   = 1'b1;
          case (q_head.kind)
            fvbt_pkg::CMD_CLEAR: state_next = fvbt_pkg::S_CLR;
            fvbt_pkg::CMD_WRITE, fvbt_pkg::CMD_READ: state_next = fvbt_pkg::S_RMW;
            fvbt_pkg::CMD_ROWQ, fvbt_pkg::CMD_COLQ: state_next = fvbt_pkg::S_FOLD;
            default: state_next = fvbt_pkg::S_FIN;
          endcase
        end
      end
      fvbt_pkg::S_CLR: begin
        // Sweep one column word and one count of each kind per cycle.
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = '0;
        rc_we     = 1'b1;
        cc_we     = 1'b1;
        rc_addr   = fvbt_pkg::ROW_W'(idx);
        cc_addr   = idx;
        rc_wdata  = '0;
        cc_wdata  = '0;
        idx_next  = idx + 1'b1;
        if (idx == fvbt_pkg::COL_W'(fvbt_pkg::MAX_COLS - 1)) begin
          state_next = fvbt_pkg::S_FIN;
        end
      end
      fvbt_pkg::S_RMW: begin
        if (cmd.kind == fvbt_pkg::CMD_WRITE) begin
          mem_we = 1'b1;
          mem_wdata[{cmd.row, 1'b0} +: 2] = cmd.val;
          if (cmd.val == fvbt_pkg::V_TRUE) begin
            rc_we = 1'b1;
            cc_we = 1'b1;
          end
        end else begin
          res_next.cell_out = slice;
        end
        state_next = fvbt_pkg::S_FIN;
      end
      fvbt_pkg::S_FOLD: begin
        // The word read last cycle holds element idx of the line.
        sel          = (cmd.kind == fvbt_pkg::CMD_ROWQ) ? cmd.row : fvbt_pkg::ROW_W'(idx);
        acc_and_next = fvbt_pkg::and4(acc_and, slice);
        acc_or_next  = fvbt_pkg::or4(acc_or, slice);
        if ({1'b0, idx} == cmd.len - 1'b1) begin
          res_next.and_fold   = acc_and_next;
          res_next.or_fold    = acc_or_next;
          res_next.true_count = 16'(cnt_sel);
          state_next          = fvbt_pkg::S_FIN;
        end else begin
          idx_next  = idx + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = (cmd.kind == fvbt_pkg::CMD_ROWQ) ? idx + 1'b1 : cmd.col;
        end
      end
      fvbt_pkg::S_FIN: begin
        if (!out_valid || pop) begin
          state_next = fvbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fvbt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/four_valued_bool_table_engine_top.sv =====
// Top level of the four-valued logic table engine.
//
//   channel   handshake          payload
//   input     push / full        item   (action, col_index, row_index, cell_in)
//   result    empty / pop        result (status, cell_out, and_fold, or_fold, true_count)
//   config    cfg_we             cfg_index, cfg_data
//
// Each item is handled by one back-end sequence: only the finish state for errors,
// a read-modify-write of a column word for a write or read, one memory read per
// folded cell for a row or column query, and a sweep of the 64 column words and
// counts for a clear. Reset leaves the table not ready; the memories hold nothing
// meaningful until the first clear. A two-entry command queue lets the front take
// items while the back end works or waits on a full result register.
module four_valued_bool_table_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  fvbt_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output fvbt_pkg::out_item_t result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);

  fvbt_pkg::cmd_t cmd, q_head;
  logic           q_empty, q_pop;

  fvbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push && !full),
    .item      (item),
    .cmd       (cmd)
  );

  fvbt_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (cmd),
    .full  (full),
    .rd    (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  fvbt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== tb/sv/four_valued_bool_table_engine_top_test.sv =====
// Testbench for the four-valued logic table engine: directed and randomized actions checked against a predictor.
`timescale 1ns / 100ps

module four_valued_bool_table_engine_top_test;
  import fvbt_pkg::*;

  localparam int TIMEOUT_CYCLES = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;
  logic      cfg_we;
  logic      cfg_index;
  logic [6:0] cfg_data;

  four_valued_bool_table_engine_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [1:0]  table_cells [MAX_COLS][MAX_ROWS];
  logic [15:0] row_trues [MAX_ROWS];
  logic [15:0] col_trues [MAX_COLS];
  bit          ready_flag;
  int          cols_reg, rows_reg, live_cols, live_rows;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        failures;
  int        idle_pct;
  int        hold_off;
  int        stuck_cycles;

  // Four-valued AND/OR, written from the fold rules.
  function automatic logic [1:0] fold_and(logic [1:0] a, logic [1:0] b);
    if (a == V_FALSE || a == V_ERROR) return a;
    if (b != V_TRUE) return b;
    return a;
  endfunction

  function automatic logic [1:0] fold_or(logic [1:0] a, logic [1:0] b);
    if (a == V_TRUE || a == V_ERROR) return a;
    if (b != V_FALSE) return b;
    return a;
  endfunction

  function automatic int clamp_size(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Applies one accepted item to the table copy and returns its result.
  function automatic out_item_t predict_table(in_item_t it);
    out_item_t  r;
    logic [1:0] acc_a, acc_o;
    bit         need_col, need_row;
    r = '0;
    if (it.action == ACT_CLEAR) begin
      live_cols = clamp_size(cols_reg, MAX_COLS);
      live_rows = clamp_size(rows_reg, MAX_ROWS);
      foreach (table_cells[c, w]) table_cells[c][w] = V_FALSE;
      foreach (row_trues[w]) row_trues[w] = '0;
      foreach (col_trues[c]) col_trues[c] = '0;
      ready_flag = 1;
    end else if (it.action <= ACT_COLQ) begin
      need_col = (it.action != ACT_ROWQ);
      need_row = (it.action != ACT_COLQ);
      if (!ready_flag) begin
        r.status = ST_NOT_READY;
      end else if ((need_col && it.col_index >= live_cols) ||
                   (need_row && it.row_index >= live_rows)) begin
        r.status = ST_BAD_INDEX;
      end else if (it.action == ACT_WRITE) begin
        table_cells[it.col_index][it.row_index] = it.cell_in;
        if (it.cell_in == V_TRUE) begin
          if (row_trues[it.row_index] != 16'hFFFF) row_trues[it.row_index]++;
          if (col_trues[it.col_index] != 16'hFFFF) col_trues[it.col_index]++;
        end
      end else if (it.action == ACT_READ) begin
        r.cell_out = table_cells[it.col_index][it.row_index];
      end else begin
        acc_a = V_TRUE;
        acc_o = V_FALSE;
        if (it.action == ACT_ROWQ) begin
          for (int i = 0; i < live_cols; i++) begin
            acc_a = fold_and(acc_a, table_cells[i][it.row_index]);
            acc_o = fold_or(acc_o, table_cells[i][it.row_index]);
          end
          r.true_count = row_trues[it.row_index];
        end else begin
          for (int i = 0; i < live_rows; i++) begin
            acc_a = fold_and(acc_a, table_cells[it.col_index][i]);
            acc_o = fold_or(acc_o, table_cells[it.col_index][i]);
          end
          r.true_count = col_trues[it.col_index];
        end
        r.and_fold = acc_a;
        r.or_fold  = acc_o;
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_item(logic [2:0] a, int c, int w, logic [1:0] v);
    in_item_t it;
    it.action    = a;
    it.col_index = c[COL_W-1:0];
    it.row_index = w[ROW_W-1:0];
    it.cell_in   = v;
    return it;
  endfunction

  // Random item biased toward the active area so queries find data.
  function automatic in_item_t random_item();
    int         pick;
    logic [2:0] a;
    pick = $urandom_range(99);
    if (pick < 1)       a = ACT_CLEAR;
    else if (pick < 50) a = ACT_WRITE;
    else if (pick < 65) a = ACT_READ;
    else if (pick < 78) a = ACT_ROWQ;
    else if (pick < 91) a = ACT_COLQ;
    else if (pick < 94) a = 3'($urandom_range(5, 7));
    else                a = 3'($urandom_range(1, 4));
    if (pick >= 94)
      return make_item(a, $urandom_range(63), $urandom_range(63), 2'($urandom));
    return make_item(a, $urandom_range(clamp_size(cols_reg, MAX_COLS) - 1),
                     $urandom_range(clamp_size(rows_reg, MAX_ROWS) - 1),
                     ($urandom_range(2) == 0) ? V_TRUE : 2'($urandom));
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Sender: transfer the next pending item, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 0;
      item <= '0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_table(item));
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && ($urandom_range(99) >= idle_pct)) begin
        push <= 1;
        item <= pending_items[0];
      end else begin
        push <= 0;
      end
    end
  end

  // Receiver: check each transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          failures++;
        end else begin
          if (result !== expected_results[0]) begin
            $display("%0t: mismatch expected %h actual %h (st/cell/and/or/cnt)",
                     $time, expected_results[0], result);
            failures++;
          end
          void'(expected_results.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= TIMEOUT_CYCLES) begin
        $display("four_valued_bool_table_engine_top test failed");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= 7'(value);
    @(posedge clk);
    cfg_we <= 0;
    cols_reg = (idx == REG_COLS) ? value : cols_reg;
    rows_reg = (idx == REG_ROWS) ? value : rows_reg;
  endtask

  initial begin
    int col_set [6] = '{64, 1, 0, 127, 5, 37};
    int row_set [6] = '{64, 0, 1, 100, 9, 50};
    failures = 0;
    idle_pct = 37;
    hold_off = 0;
    ready_flag = 0;
    cols_reg = 64;
    rows_reg = 64;
    live_cols = 0;
    live_rows = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_COLS;
    cfg_data = '0;
    push = 0;
    pop = 0;
    item = '0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: not-ready items, unknown action, then clear and extremes.
    pending_items.push_back(make_item(ACT_READ, 0, 0, V_FALSE));
    pending_items.push_back(make_item(ACT_WRITE, 63, 63, V_TRUE));
    pending_items.push_back(make_item(ACT_ROWQ, 0, 0, V_FALSE));
    pending_items.push_back(make_item(ACT_COLQ, 0, 0, V_FALSE));
    pending_items.push_back(make_item(3'd7, 63, 63, V_ERROR));
    pending_items.push_back(make_item(ACT_CLEAR, 0, 0, V_FALSE));
    pending_items.push_back(make_item(ACT_ROWQ, 0, 63, V_FALSE));
    pending_items.push_back(make_item(ACT_WRITE, 63, 63, V_TRUE));
    pending_items.push_back(make_item(ACT_WRITE, 0, 63, V_UNDEF));
    pending_items.push_back(make_item(ACT_WRITE, 5, 63, V_ERROR));
    pending_items.push_back(make_item(ACT_WRITE, 63, 63, V_TRUE));
    pending_items.push_back(make_item(ACT_READ, 63, 63, V_FALSE));
    pending_items.push_back(make_item(ACT_ROWQ, 0, 63, V_FALSE));
    pending_items.push_back(make_item(ACT_COLQ, 63, 0, V_FALSE));
    pending_items.push_back(make_item(3'd5, 0, 0, V_FALSE));
    pending_items.push_back(make_item(3'd6, 0, 0, V_FALSE));
    wait_idle();

    // Phases across register settings; first phase without idling,
    // second with a long receiver hold-off so the input stalls.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_COLS, col_set[ph]);
      write_reg(REG_ROWS, row_set[ph]);
      idle_pct = (ph == 0) ? 0 : 37;
      pending_items.push_back(make_item(ACT_CLEAR, 0, 0, V_FALSE));
      pending_items.push_back(make_item(ACT_WRITE, 63, 63, V_TRUE));
      pending_items.push_back(make_item(ACT_READ, 0, 63, V_FALSE));
      for (int n = 0; n < 165; n++) pending_items.push_back(random_item());
      if (ph == 1) hold_off = 400;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("four_valued_bool_table_engine_top test passed");
    end else begin
      $display("four_valued_bool_table_engine_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fvbt_pkg.sv
hdl/fvbt_front.sv
hdl/fvbt_cmd_fifo.sv
hdl/fvbt_back.sv
hdl/four_valued_bool_table_engine_top.sv
tb/sv/four_valued_bool_table_engine_top_test.sv
